### rtl/core/lpil_pkg.sv
// Shared constants for the length-prefixed image loader.
// Phase codes, result kinds and the sync byte; no dependencies.
`timescale 1ns / 1ps

package lpil_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'h53;

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_LEN0 = 3'd1;
	localparam logic [2:0] PH_LEN1 = 3'd2;
	localparam logic [2:0] PH_LEN2 = 3'd3;
	localparam logic [2:0] PH_LEN3 = 3'd4;
	localparam logic [2:0] PH_DATA = 3'd5;

	localparam logic [1:0] KIND_WRITE    = 2'd0;
	localparam logic [1:0] KIND_FINAL    = 2'd1;
	localparam logic [1:0] KIND_BAD_SIZE = 2'd2;

	localparam logic [7:0] CFG_BASE_ADDR  = 8'd0;
	localparam logic [7:0] CFG_SIZE_LIMIT = 8'd1;

	localparam logic [31:0] SIZE_LIMIT_RESET = 32'd262144;

	typedef logic [2:0] phase_t;
	typedef logic [1:0] kind_t;

endpackage

### rtl/core/length_prefixed_image_loader.sv
// Length-prefixed image loader: top level, sync hunt, length capture and payload writes.
// Depends on lpil_pkg for phase codes, result kinds and the sync byte.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_ready / rx_byte) carries one received byte per transfer.
//   The block discards bytes until the sync byte 'S', then gathers a 4-byte
//   little-endian length. A zero length or one above size_limit yields one
//   invalid-size result and the block goes back to hunting. Otherwise each of
//   the next length bytes yields one write result at base_addr + offset; the
//   last of them also carries byte count, wrapping 32-bit sum and last byte.
//   Output channel (out_valid / out_ready / kind ... last_byte) carries at most
//   one result per input transfer.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
//   base_addr, index 1 is size_limit (low 32 bits); other indexes are dropped.
//   cfg_ready is always high; write only while the block is idle.
// Timing: one byte per cycle sustained; a result sits in the output register
//   from the edge its byte transfers on. The single output register sets the
//   rate: take a new byte whenever it is empty or drains.
// Reset: arst_n clears phase, counters, sum and output valid, and restores the
//   register defaults (base_addr 0, size_limit 262144).
// Stall: while out_valid is high and out_ready low, in_ready drops and parser and output state hold.

module length_prefixed_image_loader
	import lpil_pkg::*;
#(
	parameter int ADDR_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            rx_byte,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            kind,
	output logic [ADDR_WIDTH-1:0] write_addr,
	output logic [7:0]            write_data,
	output logic [31:0]           byte_count,
	output logic [31:0]           byte_sum,
	output logic [7:0]            last_byte,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [7:0]            cfg_index,
	input  logic [63:0]           cfg_data
);

	// configuration registers
	logic [63:0] base_addr_q;
	logic [31:0] size_limit_q;

	// parser state
	phase_t      phase_q;
	logic [31:0] length_q;
	logic [31:0] offset_q;
	logic [31:0] sum_q;

	// output register
	logic                  out_valid_q;
	kind_t                 kind_q;
	logic [ADDR_WIDTH-1:0] addr_q;
	logic [7:0]            data_q;
	logic [31:0]           count_q;
	logic [31:0]           bsum_q;
	logic [7:0]            last_q;

	// next-state and result logic
	logic        in_fire;
	phase_t      phase_d;
	logic [31:0] length_d;
	logic [31:0] offset_d;
	logic [31:0] sum_d;
	logic        res_valid;
	kind_t       res_kind;
	logic [63:0] addr_full;
	logic [31:0] len_full;
	logic [31:0] offset_inc;
	logic [31:0] sum_inc;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;

	assign addr_full  = base_addr_q + {32'd0, offset_q};
	assign offset_inc = offset_q + 32'd1;
	assign sum_inc    = sum_q + {24'd0, rx_byte};

	always_comb begin
		len_full = length_q;
		unique case (phase_q)
			PH_LEN0: len_full = length_q | {24'd0, rx_byte};
			PH_LEN1: len_full = length_q | {16'd0, rx_byte, 8'd0};
			PH_LEN2: len_full = length_q | {8'd0, rx_byte, 16'd0};
			PH_LEN3: len_full = length_q | {rx_byte, 24'd0};
			default: len_full = length_q;
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		length_d  = length_q;
		offset_d  = offset_q;
		sum_d     = sum_q;
		res_valid = 1'b0;
		res_kind  = KIND_WRITE;
		unique case (phase_q) inside
			PH_LEN0, PH_LEN1, PH_LEN2: begin
				length_d = len_full;
				phase_d  = phase_q + 3'd1;
			end
			PH_LEN3: begin
				if (len_full == 32'd0 || len_full > size_limit_q) begin
					// bad size: report and rearm
					res_valid = 1'b1;
					res_kind  = KIND_BAD_SIZE;
					phase_d   = PH_HUNT;
					length_d  = 32'd0;
				end else begin
					length_d = len_full;
					phase_d  = PH_DATA;
					offset_d = 32'd0;
					sum_d    = 32'd0;
				end
			end
			PH_DATA: begin
				res_valid = 1'b1;
				if (offset_inc >= length_q) begin
					res_kind = KIND_FINAL;
					phase_d  = PH_HUNT;
					length_d = 32'd0;
					offset_d = 32'd0;
					sum_d    = 32'd0;
				end else begin
					res_kind = KIND_WRITE;
					offset_d = offset_inc;
					sum_d    = sum_inc;
				end
			end
			default: begin
				// hunting, unused codes fall here too
				phase_d = PH_HUNT;
				if (rx_byte == SYNC_BYTE) begin
					phase_d  = PH_LEN0;
					length_d = 32'd0;
					offset_d = 32'd0;
					sum_d    = 32'd0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_addr_q  <= 64'd0;
			size_limit_q <= SIZE_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BASE_ADDR:  base_addr_q  <= cfg_data;
				CFG_SIZE_LIMIT: size_limit_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			length_q <= 32'd0;
			offset_q <= 32'd0;
			sum_q    <= 32'd0;
		end else if (in_fire) begin
			phase_q  <= phase_d;
			length_q <= length_d;
			offset_q <= offset_d;
			sum_q    <= sum_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_fire && res_valid;
		end
	end

	// payload: load on every transfer that produces a result
	always_ff @(posedge clk) begin
		if (in_fire && res_valid) begin
			kind_q <= res_kind;
			if (res_kind == KIND_BAD_SIZE) begin
				addr_q <= '0;
				data_q <= 8'd0;
			end else begin
				addr_q <= addr_full[ADDR_WIDTH-1:0];
				data_q <= rx_byte;
			end
			if (res_kind == KIND_FINAL) begin
				count_q <= length_q;
				bsum_q  <= sum_inc;
				last_q  <= rx_byte;
			end else begin
				count_q <= 32'd0;
				bsum_q  <= 32'd0;
				last_q  <= 8'd0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign write_addr = addr_q;
	assign write_data = data_q;
	assign byte_count = count_q;
	assign byte_sum   = bsum_q;
	assign last_byte  = last_q;

	// checks
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (kind_q == KIND_WRITE || kind_q == KIND_FINAL ||
			kind_q == KIND_BAD_SIZE))
		else $error("illegal result kind");

	a_final_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_FINAL) |-> (count_q != 32'd0))
		else $error("final write with zero byte count");

	a_offset_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (offset_q < length_q))
		else $error("payload offset reached length");

	a_bad_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && res_valid && res_kind == KIND_BAD_SIZE) |=>
			(phase_q == PH_HUNT && length_q == 32'd0))
		else $error("no rearm after invalid size");

endmodule

### test/length_prefixed_image_loader_tb.sv
// Self-checking testbench for the length-prefixed image loader.
// Depends on lpil_pkg and length_prefixed_image_loader; runs stand-alone.
`timescale 1ns / 1ps

module length_prefixed_image_loader_tb;
	import lpil_pkg::*;

	localparam int ADDR_W = 64;
	localparam logic [63:0] ADDR_MASK = {64{1'b1}} >> (64 - ADDR_W);
	// Register indexes past the end of the map; the block must drop these writes.
	localparam logic [7:0] CFG_UNMAPPED_LO = 8'd2;
	localparam logic [7:0] CFG_UNMAPPED_HI = 8'd255;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 250;

	// One memory write, final write or size error as seen on the result port.
	typedef struct {
		kind_t       kind;
		logic [63:0] addr;
		logic [7:0]  data;
		logic [31:0] count;
		logic [31:0] total;
		logic [7:0]  last_b;
	} load_result_t;

	// Mirrors the loader: tracks sync hunt, length capture and payload offset,
	// and queues the result, if any, that each received byte should produce.
	class load_scoreboard;
		logic [63:0]  base_addr;
		logic [31:0]  size_limit;
		phase_t       phase;
		logic [31:0]  length;
		logic [31:0]  offset;
		logic [31:0]  running_sum;
		load_result_t pending[$];
		int           errors;

		function new();
			base_addr   = '0;
			size_limit  = SIZE_LIMIT_RESET;
			phase       = PH_HUNT;
			length      = '0;
			offset      = '0;
			running_sum = '0;
			errors      = 0;
		endfunction

		function void write_reg(logic [7:0] idx, logic [63:0] value);
			if (idx == CFG_BASE_ADDR) begin
				base_addr = value;
			end else if (idx == CFG_SIZE_LIMIT) begin
				size_limit = value[31:0];
			end
		endfunction

		function void note_byte(logic [7:0] b);
			load_result_t r;
			int           shift;
			r.kind   = KIND_WRITE;
			r.addr   = '0;
			r.data   = '0;
			r.count  = '0;
			r.total  = '0;
			r.last_b = '0;
			case (phase) inside
				PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3: begin
					shift  = 8 * int'(phase - PH_LEN0);
					length = length | ({24'd0, b} << shift);
					if (phase != PH_LEN3) begin
						phase = phase + 3'd1;
					end else if (length == 0 || length > size_limit) begin
						r.kind = KIND_BAD_SIZE;
						pending.push_back(r);
						phase  = PH_HUNT;
						length = '0;
					end else begin
						phase       = PH_DATA;
						offset      = '0;
						running_sum = '0;
					end
				end
				PH_DATA: begin
					r.addr      = (base_addr + {32'd0, offset}) & ADDR_MASK;
					r.data      = b;
					running_sum = running_sum + {24'd0, b};
					offset      = offset + 32'd1;
					if (offset >= length) begin
						// Last payload byte: report the summary and rearm.
						r.kind      = KIND_FINAL;
						r.count     = length;
						r.total     = running_sum;
						r.last_b    = b;
						phase       = PH_HUNT;
						length      = '0;
						offset      = '0;
						running_sum = '0;
					end
					pending.push_back(r);
				end
				default: begin
					phase = PH_HUNT;
					if (b == SYNC_BYTE) begin
						phase       = PH_LEN0;
						length      = '0;
						offset      = '0;
						running_sum = '0;
					end
				end
			endcase
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function void check_result(load_result_t got);
			load_result_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual kind %0d addr %h",
					$time, got.kind, got.addr);
				return;
			end
			want = pending.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("write_addr", want.addr, got.addr);
			compare_field("write_data", want.data, got.data);
			compare_field("byte_count", want.count, got.count);
			compare_field("byte_sum", want.total, got.total);
			compare_field("last_byte", want.last_b, got.last_b);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [7:0]            rx_byte;
	logic                  out_valid;
	logic                  out_ready;
	logic [1:0]            kind;
	logic [ADDR_W-1:0]     write_addr;
	logic [7:0]            write_data;
	logic [31:0]           byte_count;
	logic [31:0]           byte_sum;
	logic [7:0]            last_byte;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [7:0]            cfg_index;
	logic [63:0]           cfg_data;

	load_scoreboard sb = new();

	// Flow control knobs shared by the sender, the receiver and the sequence.
	bit src_free;
	bit sink_free;
	bit hold_req;
	int items_sent;

	length_prefixed_image_loader #(
		.ADDR_WIDTH(ADDR_W)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.write_addr(write_addr),
		.write_data(write_data),
		.byte_count(byte_count),
		.byte_sum  (byte_sum),
		.last_byte (last_byte),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return $urandom_range(1, 3);
		end else if (r < 95) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Sample every handshake at the rising edge; the scoreboard sees transfers
	// in the order the block does.
	always @(posedge clk) begin
		load_result_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				sb.write_reg(cfg_index, cfg_data);
			end
			if (in_valid && in_ready) begin
				sb.note_byte(rx_byte);
			end
			if (out_valid && out_ready) begin
				got.kind   = kind;
				got.addr   = 64'(write_addr);
				got.data   = write_data;
				got.count  = byte_count;
				got.total  = byte_sum;
				got.last_b = last_byte;
				sb.check_result(got);
			end
		end
	end

	// Receiver: random back-pressure, plus one long hold-off on request so the
	// output register fills and the block stalls its input.
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (sink_free) begin
				out_ready  = 1'b1;
				stall_left = 0;
			end else if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				out_ready = 1'b1;
				if ($urandom_range(0, 99) < 20) begin
					stall_left = pick_gap();
				end
			end
		end
	end

	// Offer one byte and hold it until the transfer; leave valid high so a
	// back-to-back byte follows without a bubble. Called at a falling edge.
	task automatic send_byte(logic [7:0] b);
		int gap;
		in_valid = 1'b1;
		rx_byte  = b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		gap = 0;
		if (!src_free && $urandom_range(0, 99) < 25) begin
			gap = pick_gap();
		end
		if (gap > 0) begin
			in_valid = 1'b0;
			rx_byte  = 8'($urandom);
			repeat (gap) @(negedge clk);
		end
	endtask

	// Sync byte, little-endian length, then n_payload random bytes.
	task automatic send_frame(logic [31:0] len_field, int n_payload);
		send_byte(SYNC_BYTE);
		for (int i = 0; i < 4; i++) begin
			send_byte(len_field[8*i +: 8]);
		end
		for (int i = 0; i < n_payload; i++) begin
			send_byte(8'($urandom));
		end
		items_sent += 5 + n_payload;
	endtask

	// Stop offering, then wait out every pending result and the block's latency.
	task automatic drain();
		in_valid = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(logic [7:0] idx, logic [63:0] value);
		cfg_index = idx;
		cfg_data  = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Random traffic: mostly well-formed frames, some bad sizes, some cut-off
	// frames and some line noise between them.
	task automatic run_phase(int budget);
		int          stop_at;
		int          r;
		int          n_noise;
		int unsigned cap;
		int unsigned len;
		logic [63:0] span;
		logic [31:0] bad_len;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			r   = $urandom_range(0, 99);
			cap = ($urandom_range(0, 99) < 90) ? 8 : 40;
			if (sb.size_limit < cap) begin
				cap = sb.size_limit;
			end
			if (r < 72 && cap > 0) begin
				len = ($urandom_range(0, 9) == 0) ? cap : $urandom_range(1, cap);
				send_frame(len, len);
			end else if (r < 86) begin
				// Zero length or a length above the limit: size error.
				span    = 64'hFFFF_FFFF - {32'd0, sb.size_limit};
				bad_len = '0;
				if (span != 0 && $urandom_range(0, 3) != 0) begin
					bad_len = 32'({32'd0, sb.size_limit} + 64'd1 +
						({32'd0, $urandom} % span));
				end
				send_frame(bad_len, 0);
			end else if (r < 92 && cap > 1) begin
				// Cut the payload short; following bytes land in the payload.
				len = $urandom_range(2, cap);
				send_frame(len, $urandom_range(0, len - 1));
			end else begin
				n_noise = $urandom_range(1, 4);
				repeat (n_noise) send_byte(8'($urandom));
				items_sent += n_noise;
			end
		end
	endtask

	initial begin
		logic [7:0] directed_seq[] = '{
			8'h00, 8'hFF,
			SYNC_BYTE, 8'h00, 8'h00, 8'h00, 8'h00,
			SYNC_BYTE, 8'h01, 8'h00, 8'h00, 8'h00, 8'hFF,
			SYNC_BYTE, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hA5,
			SYNC_BYTE, 8'h01, 8'h00, 8'h04, 8'h00
		};
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		rx_byte    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		src_free   = 1'b0;
		sink_free  = 1'b0;
		hold_req   = 1'b0;
		items_sent = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed pass on reset defaults: ignored noise, zero length,
		// one-byte image, short image and a length just over the limit.
		foreach (directed_seq[i]) begin
			send_byte(directed_seq[i]);
		end
		items_sent += directed_seq.size();
		run_phase(PHASE_ITEMS);
		drain();

		// Base near the top of the map; tiny limit hit exactly.
		cfg_write(CFG_BASE_ADDR, 64'hFFFF_FFFF_FFFF_FFF0);
		cfg_write(CFG_SIZE_LIMIT, 64'd8);
		run_phase(PHASE_ITEMS);
		drain();

		// Zero limit: every length is rejected.
		cfg_write(CFG_BASE_ADDR, {$urandom, $urandom});
		cfg_write(CFG_SIZE_LIMIT, 64'd0);
		run_phase(PHASE_ITEMS / 2);
		drain();

		// Widest limit, base at zero; hold the receiver off while the sender
		// keeps pushing so the input side backs up.
		cfg_write(CFG_BASE_ADDR, 64'd0);
		cfg_write(CFG_SIZE_LIMIT, 64'hFFFF_FFFF_FFFF_FFFF);
		src_free = 1'b1;
		hold_req = 1'b1;
		run_phase(PHASE_ITEMS);
		src_free = 1'b0;
		drain();

		// Single-byte limit with the base at the very last address.
		cfg_write(CFG_BASE_ADDR, 64'hFFFF_FFFF_FFFF_FFFF);
		cfg_write(CFG_SIZE_LIMIT, 64'd1);
		run_phase(PHASE_ITEMS);
		drain();

		// Random settings; writes to unmapped indexes must change nothing.
		cfg_write(CFG_BASE_ADDR, {$urandom, $urandom});
		cfg_write(CFG_SIZE_LIMIT, 64'($urandom_range(1, 64)));
		cfg_write(CFG_UNMAPPED_LO, {$urandom, $urandom});
		cfg_write(CFG_UNMAPPED_HI, {$urandom, $urandom});
		run_phase(PHASE_ITEMS);
		drain();

		// Back to the default limit; run with no idling on either side, then with random idling.
		cfg_write(CFG_BASE_ADDR, {$urandom, $urandom});
		cfg_write(CFG_SIZE_LIMIT, 64'(SIZE_LIMIT_RESET));
		src_free  = 1'b1;
		sink_free = 1'b1;
		run_phase(PHASE_ITEMS);
		src_free  = 1'b0;
		sink_free = 1'b0;
		run_phase(PHASE_ITEMS / 2);

		drain();
		repeat (10) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("length_prefixed_image_loader_tb passed");
		end else begin
			$display("length_prefixed_image_loader_tb failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("length_prefixed_image_loader_tb failed");
		$finish;
	end

endmodule
